[rtl/core/rbs_pkg.sv]
// rbs_pkg: shared types and constants for the room booking scheduler.
// No dependencies; imported by rbs_room_state, room_booking_scheduler and rbs_checker.
`default_nettype none

package rbs_pkg;

    localparam int TIME_W  = 40;
    localparam int COUNT_W = 32;
    localparam int STAMP_W = 32;
    localparam int ROOM_W  = 4;
    localparam int CFG_W   = 5;

    // rooms in use after reset
    localparam logic [CFG_W-1:0] ACTIVE_RESET = 5'd16;

    localparam logic [TIME_W-1:0]  TIME_MAX  = '1;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef struct packed {
        logic [STAMP_W-1:0] start_time;
        logic [STAMP_W-1:0] end_time;
    } t_req;

    typedef struct packed {
        logic [ROOM_W-1:0] room;
        logic              delayed;
        logic [TIME_W-1:0] finish_time;
        logic [ROOM_W-1:0] most_booked_room;
    } t_res;

    // room grant handed from the assignment stage to the ranking stage
    typedef struct packed {
        logic              valid;
        logic [ROOM_W-1:0] room;
        logic              delayed;
        logic [TIME_W-1:0] finish_time;
    } t_grant;

endpackage

`default_nettype wire

[rtl/core/rbs_sel_tree.sv]
// rbs_sel_tree: binary selection tree picking the min or max key among valid
// entries, lower index wins ties. Depends on nothing but its parameters.
`default_nettype none

module rbs_sel_tree #(
    parameter int N        = 16,
    parameter int KEY_W    = 40,
    parameter int IDX_W    = 4,
    parameter bit PICK_MAX = 1'b0
) (
    input  wire logic [N-1:0]            i_valid,
    input  wire logic [N-1:0][KEY_W-1:0] i_key,
    output logic      [IDX_W-1:0]        o_idx,
    output logic      [KEY_W-1:0]        o_key
);

    localparam int POW = 1 << IDX_W;

    logic             leaf_v [POW];
    logic [KEY_W-1:0] leaf_k [POW];
    logic [IDX_W-1:0] leaf_x [POW];

    logic             nv [POW];
    logic [KEY_W-1:0] nk [POW];
    logic [IDX_W-1:0] nx [POW];

    genvar g;
    generate
        for (g = 0; g < POW; g++) begin : g_leaf
            if (g < N) begin : g_used
                assign leaf_v[g] = i_valid[g];
                assign leaf_k[g] = i_key[g];
            end else begin : g_pad
                assign leaf_v[g] = 1'b0;
                assign leaf_k[g] = '0;
            end
            assign leaf_x[g] = IDX_W'(g);
        end
    endgenerate

    always_comb begin
        logic take;
        take = 1'b0;
        for (int j = 0; j < POW; j++) begin
            nv[j] = leaf_v[j];
            nk[j] = leaf_k[j];
            nx[j] = leaf_x[j];
        end
        // node j absorbs node j + 2^l at each level; left side wins ties
        for (int l = 0; l < IDX_W; l++) begin
            for (int j = 0; j < POW; j += (2 << l)) begin
                if (PICK_MAX) begin
                    take = nv[j + (1 << l)] &&
                           (!nv[j] || (nk[j + (1 << l)] > nk[j]));
                end else begin
                    take = nv[j + (1 << l)] &&
                           (!nv[j] || (nk[j + (1 << l)] < nk[j]));
                end
                if (take) begin
                    nv[j] = nv[j + (1 << l)];
                    nk[j] = nk[j + (1 << l)];
                    nx[j] = nx[j + (1 << l)];
                end
            end
        end
    end

    assign o_idx = nx[0];
    assign o_key = nk[0];

endmodule

`default_nettype wire

[rtl/core/rbs_room_state.sv]
// rbs_room_state: per-room busy-until and booking-count registers, room mask,
// and the registered room assignment. Depends on rbs_pkg and rbs_sel_tree.
`default_nettype none

module rbs_room_state
    import rbs_pkg::*;
#(
    parameter int MAX_ROOMS = 16,
    parameter int IDX_W     = 4
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [CFG_W-1:0]                  i_cfg_wdata,
    input  wire logic                              i_req_valid,
    input  wire t_req                              i_req,
    output t_grant                                 o_grant,
    output logic      [MAX_ROOMS-1:0]              o_active,
    output logic      [MAX_ROOMS-1:0][COUNT_W-1:0] o_count
);

    localparam int CMP_W = CFG_W + 2;

    logic [MAX_ROOMS-1:0]              r_active, n_active;
    logic [MAX_ROOMS-1:0]              reset_mask;
    logic [MAX_ROOMS-1:0][TIME_W-1:0]  r_busy;
    logic [MAX_ROOMS-1:0][COUNT_W-1:0] r_count;
    t_grant                            r_grant, n_grant;

    logic [CFG_W-1:0]    eff_rooms;
    logic [MAX_ROOMS-1:0] free;
    logic                 found;
    logic [IDX_W-1:0]     free_idx, min_idx, pick;
    logic [TIME_W-1:0]    min_key, begin_t, fin;
    logic [STAMP_W-1:0]   len;
    logic [TIME_W:0]      sum;
    logic [IDX_W+ROOM_W-1:0] pick_ext;

    // a room count of zero means one room
    assign eff_rooms = (i_cfg_wdata == '0) ? CFG_W'(1) : i_cfg_wdata;

    genvar g;
    generate
        for (g = 0; g < MAX_ROOMS; g++) begin : g_room
            assign n_active[g]   = CMP_W'(g) < {2'b00, eff_rooms};
            assign reset_mask[g] = CMP_W'(g) < {2'b00, ACTIVE_RESET};
            assign free[g] = r_active[g] &&
                             (r_busy[g] <= {{(TIME_W-STAMP_W){1'b0}}, i_req.start_time});
        end
    endgenerate

    always_comb begin
        found    = 1'b0;
        free_idx = '0;
        for (int i = MAX_ROOMS - 1; i >= 0; i--) begin
            if (free[i]) begin
                found    = 1'b1;
                free_idx = IDX_W'(i);
            end
        end
    end

    rbs_sel_tree #(
        .N        (MAX_ROOMS),
        .KEY_W    (TIME_W),
        .IDX_W    (IDX_W),
        .PICK_MAX (1'b0)
    ) u_min_busy (
        .i_valid (r_active),
        .i_key   (r_busy),
        .o_idx   (min_idx),
        .o_key   (min_key)
    );

    assign pick    = found ? free_idx : min_idx;
    assign begin_t = found ? {{(TIME_W-STAMP_W){1'b0}}, i_req.start_time} : min_key;
    assign len     = (i_req.end_time > i_req.start_time) ?
                     (i_req.end_time - i_req.start_time) : '0;
    assign sum     = {1'b0, begin_t} + {{(TIME_W-STAMP_W+1){1'b0}}, len};
    assign fin     = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
    assign pick_ext = {{ROOM_W{1'b0}}, pick};

    always_comb begin
        n_grant.valid       = i_req_valid;
        n_grant.room        = pick_ext[ROOM_W-1:0];
        n_grant.delayed     = !found;
        n_grant.finish_time = fin;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= reset_mask;
            r_busy   <= '0;
            r_count  <= '0;
            r_grant  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_active <= n_active;
            end
            for (int i = 0; i < MAX_ROOMS; i++) begin
                if (i_req_valid && (pick == IDX_W'(i))) begin
                    r_busy[i] <= fin;
                    if (r_count[i] != COUNT_MAX) begin
                        r_count[i] <= r_count[i] + COUNT_W'(1);
                    end
                end
            end
            r_grant <= n_grant;
        end
    end

    assign o_grant  = r_grant;
    assign o_active = r_active;
    assign o_count  = r_count;

endmodule

`default_nettype wire

[rtl/core/room_booking_scheduler.sv]
// room_booking_scheduler: one request accepted every cycle; the result comes
// out with o_strobe after the stages below (input reg, assignment stage
// updating the room registers, ranking stage over booking counts).
// The receiver cannot stall; busy is high only during reset and for the first
// cycle after it. Synchronous active-low reset clears all room state and sets
// 16 rooms in use.
`default_nettype none

module room_booking_scheduler
    import rbs_pkg::*;
#(
    parameter int MAX_ROOMS = 16
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire t_req             i_req,
    input  wire logic             i_cfg_we,
    input  wire logic [CFG_W-1:0] i_cfg_wdata,
    output logic                  o_strobe,
    output t_res                  o_res
);

    localparam int IDX_W = (MAX_ROOMS > 1) ? $clog2(MAX_ROOMS) : 1;

    logic   r_rdy;
    logic   r_req_valid;
    t_req   r_req;
    logic   r_strobe;
    t_res   r_res;
    t_grant grant;

    logic [MAX_ROOMS-1:0]              active;
    logic [MAX_ROOMS-1:0][COUNT_W-1:0] count;
    logic [IDX_W-1:0]                  best_idx;
    logic [COUNT_W-1:0]                best_cnt;
    logic [IDX_W+ROOM_W-1:0]           best_ext;

    assign busy = !r_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rdy       <= 1'b0;
            r_req_valid <= 1'b0;
            r_strobe    <= 1'b0;
        end else begin
            r_rdy       <= 1'b1;
            r_req_valid <= start && !busy;
            r_strobe    <= grant.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req <= i_req;
    end

    rbs_room_state #(
        .MAX_ROOMS (MAX_ROOMS),
        .IDX_W     (IDX_W)
    ) u_state (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req_valid (r_req_valid),
        .i_req       (r_req),
        .o_grant     (grant),
        .o_active    (active),
        .o_count     (count)
    );

    // counts already include the request now held in grant
    rbs_sel_tree #(
        .N        (MAX_ROOMS),
        .KEY_W    (COUNT_W),
        .IDX_W    (IDX_W),
        .PICK_MAX (1'b1)
    ) u_max_count (
        .i_valid (active),
        .i_key   (count),
        .o_idx   (best_idx),
        .o_key   (best_cnt)
    );

    assign best_ext = {{ROOM_W{1'b0}}, best_idx};

    always_ff @(posedge i_clk) begin
        r_res.room             <= grant.room;
        r_res.delayed          <= grant.delayed;
        r_res.finish_time      <= grant.finish_time;
        r_res.most_booked_room <= (best_cnt == '0) ? '0 : best_ext[ROOM_W-1:0];
    end

    assign o_strobe = r_strobe;
    assign o_res    = r_res;

endmodule

`default_nettype wire

[rtl/core/rbs_checker.sv]
// rbs_checker: port-level checks of the room booking scheduler, bound to the
// top level. Depends on rbs_pkg.
`default_nettype none

module rbs_checker
    import rbs_pkg::*;
(
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             start,
    input wire logic             busy,
    input wire t_req             i_req,
    input wire logic             i_cfg_we,
    input wire logic [CFG_W-1:0] i_cfg_wdata,
    input wire logic             o_strobe,
    input wire t_res             o_res
);

    // every request yields exactly one result
    a_req_to_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |-> ##3 o_strobe)
        else $error("request produced no result");

    a_res_from_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy, 3))
        else $error("result without a request");

    a_finish_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |-> ##3
            (o_res.finish_time >= {8'h00, $past(i_req.start_time, 3)}))
        else $error("finish time before requested start");

    a_ontime_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_res.delayed |-> (o_res.finish_time[TIME_W-1:STAMP_W] == '0))
        else $error("undelayed request finished past its end time range");

    a_busy_after_reset: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> busy)
        else $error("request taken right after reset");

endmodule

bind room_booking_scheduler rbs_checker u_rbs_checker (.*);

`default_nettype wire
